// ----- hdl/gdo_pkg.sv -----
// Shared constants, status and command codes, and calendar tables for the date offset block.
package gdo_pkg;

    localparam logic [21:0] MAX_SERIAL = 22'd3652059;
    localparam logic [21:0] DAYS_400   = 22'd146097;
    localparam logic [17:0] DAYS_100   = 18'd36524;
    localparam logic [16:0] DAYS_4     = 17'd1461;
    localparam logic [10:0] DAYS_1     = 11'd365;

    // Reciprocal of 100 scaled by 2^19; exact for values below 43699.
    localparam logic [12:0] RECIP_100  = 13'd5243;
    localparam int          RECIP_SH   = 19;

    localparam logic [13:0] YEAR_MAX   = 14'd9999;

    localparam logic       CMD_ADD  = 1'b0;
    localparam logic       CMD_DIFF = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_DATE = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    typedef struct packed {
        logic        ok;
        logic [21:0] serial;
    } serial_t;

    // Length of a month in a common year.
    function automatic logic [4:0] month_len(logic [3:0] m);
        logic [4:0] r;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
            4'd2:                                       r = 5'd28;
            default:                                    r = 5'd0;
        endcase
        return r;
    endfunction

    // Days of a common year that lie before the first of month m.
    function automatic logic [8:0] days_before(logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/gdo_to_serial.sv -----
// Three-stage conversion of a calendar date into a day serial, with validity check.
module gdo_to_serial (
    input  logic               clk,
    input  logic               en,
    input  logic [13:0]        year,
    input  logic [3:0]         month,
    input  logic [4:0]         day,
    output gdo_pkg::serial_t   res
);

    // Stage one: year divided by 100, and the same for the year before.
    logic [13:0] y1_reg, p1_reg;
    logic [3:0]  m1_reg;
    logic [4:0]  d1_reg;
    logic [7:0]  qy1_reg, qp1_reg;
    logic [13:0] p_next;
    logic [26:0] prod_y, prod_p;

    assign p_next = year - 14'd1;
    assign prod_y = 27'(year) * 27'(gdo_pkg::RECIP_100);
    assign prod_p = 27'(p_next) * 27'(gdo_pkg::RECIP_100);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y1_reg  <= year;
            p1_reg  <= p_next;
            m1_reg  <= month;
            d1_reg  <= day;
            qy1_reg <= prod_y[gdo_pkg::RECIP_SH +: 8];
            qp1_reg <= prod_p[gdo_pkg::RECIP_SH +: 8];
        end
    end

    // Stage two: leap rule, validity, whole years in days, days before the month.
    logic [15:0] c100;
    logic        century, leap;
    logic [4:0]  dim;
    logic        ok_next;
    logic [22:0] p365_full;
    logic [8:0]  cum_next;

    assign c100    = 16'(qy1_reg) * 16'd100;
    assign century = (c100 == {2'b00, y1_reg});
    assign leap    = (y1_reg[1:0] == 2'b00) && (!century || (qy1_reg[1:0] == 2'b00));
    assign dim     = gdo_pkg::month_len(m1_reg) + 5'((leap && m1_reg == 4'd2) ? 1 : 0);
    assign ok_next = (y1_reg >= 14'd1) && (y1_reg <= gdo_pkg::YEAR_MAX)
                  && (m1_reg >= 4'd1) && (m1_reg <= 4'd12)
                  && (d1_reg >= 5'd1) && (d1_reg <= dim);
    assign p365_full = 23'(p1_reg) * 23'd365;
    assign cum_next  = gdo_pkg::days_before(m1_reg) + 9'((leap && m1_reg > 4'd2) ? 1 : 0);

    logic        ok2_reg;
    logic [21:0] p365_2_reg;
    logic [13:0] p2_reg;
    logic [7:0]  qp2_reg;
    logic [8:0]  cum2_reg;
    logic [4:0]  d2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok2_reg    <= ok_next;
            p365_2_reg <= p365_full[21:0];
            p2_reg     <= p1_reg;
            qp2_reg    <= qp1_reg;
            cum2_reg   <= cum_next;
            d2_reg     <= d1_reg;
        end
    end

    // Stage three: sum of the parts.
    logic [22:0] sum;
    gdo_pkg::serial_t res_reg;

    assign sum = 23'(p365_2_reg) + 23'(p2_reg >> 2) - 23'(qp2_reg) + 23'(qp2_reg >> 2)
               + 23'(cum2_reg) + 23'(d2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.ok     <= ok2_reg;
            res_reg.serial <= sum[21:0];
        end
    end

    assign res = res_reg;

endmodule

// ----- hdl/gdo_from_serial.sv -----
// Five-stage conversion of a day serial back into year, month and day.
module gdo_from_serial (
    input  logic        clk,
    input  logic        en,
    input  logic [21:0] serial,
    output logic [13:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day
);

    // Stage one: whole 400-year cycles.
    logic [21:0] r0;
    logic [4:0]  q400_next;
    logic [21:0] r1_full;

    assign r0 = serial - 22'd1;

    always_comb
    begin
        q400_next = 5'd0;
        for (int k = 1; k <= 24; k++)
        begin
            if (r0 >= 22'(k * 146097))
                q400_next = 5'(k);
        end
    end

    assign r1_full = r0 - 22'(q400_next) * gdo_pkg::DAYS_400;

    logic [4:0]  q400_1_reg;
    logic [17:0] r1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q400_1_reg <= q400_next;
            r1_reg     <= r1_full[17:0];
        end
    end

    // Stage two: centuries, at most three so that the last day of a cycle stays in it.
    logic [1:0]  q100_next;
    logic [17:0] r2_full;

    always_comb
    begin
        q100_next = 2'd0;
        for (int k = 1; k <= 3; k++)
        begin
            if (r1_reg >= 18'(k * 36524))
                q100_next = 2'(k);
        end
    end

    assign r2_full = r1_reg - 18'(q100_next) * gdo_pkg::DAYS_100;

    logic [4:0]  q400_2_reg;
    logic [1:0]  q100_2_reg;
    logic [16:0] r2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q400_2_reg <= q400_1_reg;
            q100_2_reg <= q100_next;
            r2_reg     <= r2_full[16:0];
        end
    end

    // Stage three: four-year groups.
    logic [4:0]  q4_next;
    logic [16:0] r3_full;

    always_comb
    begin
        q4_next = 5'd0;
        for (int k = 1; k <= 24; k++)
        begin
            if (r2_reg >= 17'(k * 1461))
                q4_next = 5'(k);
        end
    end

    assign r3_full = r2_reg - 17'(q4_next) * gdo_pkg::DAYS_4;

    logic [4:0]  q400_3_reg, q4_3_reg;
    logic [1:0]  q100_3_reg;
    logic [10:0] r3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q400_3_reg <= q400_2_reg;
            q100_3_reg <= q100_2_reg;
            q4_3_reg   <= q4_next;
            r3_reg     <= r3_full[10:0];
        end
    end

    // Stage four: single years, the year number and its leap flag.
    logic [1:0]  q1_next;
    logic [10:0] r4_full;
    logic [13:0] yy_next;
    logic        leap_next;

    always_comb
    begin
        q1_next = 2'd0;
        for (int k = 1; k <= 3; k++)
        begin
            if (r3_reg >= 11'(k * 365))
                q1_next = 2'(k);
        end
    end

    assign r4_full = r3_reg - 11'(q1_next) * gdo_pkg::DAYS_1;
    assign yy_next = 14'(q400_3_reg) * 14'd400 + 14'(q100_3_reg) * 14'd100
                   + 14'(q4_3_reg) * 14'd4 + 14'(q1_next) + 14'd1;
    // The fourth year of a group is leap, unless it closes a century that is not the fourth.
    assign leap_next = (q1_next == 2'd3) && ((q4_3_reg != 5'd24) || (q100_3_reg == 2'd3));

    logic [13:0] yy4_reg;
    logic        leap4_reg;
    logic [8:0]  r4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yy4_reg   <= yy_next;
            leap4_reg <= leap_next;
            r4_reg    <= r4_full[8:0];
        end
    end

    // Stage five: month and day within the year.
    logic [3:0] mm_next;
    logic [8:0] start;
    logic [8:0] dd_full;

    always_comb
    begin
        mm_next = 4'd1;
        for (int k = 1; k <= 11; k++)
        begin
            if (r4_reg >= gdo_pkg::days_before(4'(k + 1))
                          + 9'((leap4_reg && k >= 2) ? 1 : 0))
                mm_next = 4'(k + 1);
        end
    end

    assign start   = gdo_pkg::days_before(mm_next) + 9'((leap4_reg && mm_next > 4'd2) ? 1 : 0);
    assign dd_full = r4_reg - start + 9'd1;

    logic [13:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            year_reg  <= yy4_reg;
            month_reg <= mm_next;
            day_reg   <= dd_full[4:0];
        end
    end

    assign year  = year_reg;
    assign month = month_reg;
    assign day   = day_reg;

endmodule

// ----- hdl/gregorian_date_offset.sv -----
// Top level of the Gregorian date offset and difference block.
// Gregorian date arithmetic in a nine-stage pipeline. Each accepted item gives exactly one
// result item, and while no finished result is held at the output a new item can be accepted
// in every cycle, so the block then sustains one item per cycle; the stages are the three of date-to-serial
// conversion, one stage that adds the offset or forms the difference, and the five stages of
// serial-to-date conversion (400-year cycles, centuries, four-year groups, years, months).
// Command 0 adds offset_days to the first date; command 1 gives the first date minus the
// second in days. An invalid input date gives status 1 and a result year outside 1 to 9999
// gives status 2, with all result fields zero in both cases. The whole pipeline holds while
// a finished result waits at the output, so no item is lost or repeated under back-pressure.
module gregorian_date_offset (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic [13:0]        year,
    input  logic [3:0]         month,
    input  logic [4:0]         day,
    input  logic signed [20:0] offset_days,
    input  logic [13:0]        other_year,
    input  logic [3:0]         other_month,
    input  logic [4:0]         other_day,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [13:0]        out_year,
    output logic [3:0]         out_month,
    output logic [4:0]         out_day,
    output logic signed [22:0] diff_days,
    output logic [1:0]         status
);

    localparam int NSTAGE = 9;

    // The pipeline moves as one whenever its last stage is empty or being emptied.
    logic en;
    assign en        = !out_valid || out_ready;
    assign in_ready  = en;

    // Valid bits, one for each stage.
    logic [NSTAGE-1:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NSTAGE-2:0], in_valid};
    end

    assign out_valid = v_reg[NSTAGE-1];

    // Both dates are converted side by side.
    gdo_pkg::serial_t s1, s2;

    gdo_to_serial u_first (
        .clk   (clk),
        .en    (en),
        .year  (year),
        .month (month),
        .day   (day),
        .res   (s1)
    );

    gdo_to_serial u_second (
        .clk   (clk),
        .en    (en),
        .year  (other_year),
        .month (other_month),
        .day   (other_day),
        .res   (s2)
    );

    // The command and offset ride alongside the conversion stages.
    logic              cmd_p_reg [0:2];
    logic signed [20:0] off_p_reg [0:2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd_p_reg[0] <= cmd;
            off_p_reg[0] <= offset_days;
            for (int i = 1; i < 3; i++)
            begin
                cmd_p_reg[i] <= cmd_p_reg[i-1];
                off_p_reg[i] <= off_p_reg[i-1];
            end
        end
    end

    // Combining stage: apply the offset or form the difference, and settle the status.
    logic signed [23:0] n_sum, d_sum;
    logic               in_range;
    logic [1:0]         st_next;
    logic [22:0]        diff_next;
    logic               show_next;

    assign n_sum    = signed'({2'b00, s1.serial}) + 24'(off_p_reg[2]);
    assign d_sum    = signed'({2'b00, s1.serial}) - signed'({2'b00, s2.serial});
    assign in_range = (n_sum >= 24'sd1) && (n_sum <= signed'({2'b00, gdo_pkg::MAX_SERIAL}));

    always_comb
    begin
        st_next   = gdo_pkg::ST_OK;
        diff_next = '0;
        show_next = 1'b0;
        if (cmd_p_reg[2] == gdo_pkg::CMD_ADD)
        begin
            if (!s1.ok)
                st_next = gdo_pkg::ST_BAD_DATE;
            else if (!in_range)
                st_next = gdo_pkg::ST_RANGE;
            else
                show_next = 1'b1;
        end
        else
        begin
            if (!s1.ok || !s2.ok)
                st_next = gdo_pkg::ST_BAD_DATE;
            else
                diff_next = d_sum[22:0];
        end
    end

    logic [21:0] n_reg;
    logic [1:0]  st_q_reg   [0:5];
    logic [22:0] diff_q_reg [0:5];
    logic        show_q_reg [0:5];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg         <= n_sum[21:0];
            st_q_reg[0]   <= st_next;
            diff_q_reg[0] <= diff_next;
            show_q_reg[0] <= show_next;
            for (int i = 1; i < 6; i++)
            begin
                st_q_reg[i]   <= st_q_reg[i-1];
                diff_q_reg[i] <= diff_q_reg[i-1];
                show_q_reg[i] <= show_q_reg[i-1];
            end
        end
    end

    // Back-conversion of the shifted serial; its result is only shown for a good add.
    logic [13:0] fy;
    logic [3:0]  fm;
    logic [4:0]  fd;

    gdo_from_serial u_back (
        .clk    (clk),
        .en     (en),
        .serial (n_reg),
        .year   (fy),
        .month  (fm),
        .day    (fd)
    );

    assign out_year  = show_q_reg[5] ? fy : '0;
    assign out_month = show_q_reg[5] ? fm : '0;
    assign out_day   = show_q_reg[5] ? fd : '0;
    assign diff_days = signed'(diff_q_reg[5]);
    assign status    = st_q_reg[5];

endmodule

// ----- bench/tb_gregorian_date_offset.sv -----
// Testbench for the Gregorian date offset and difference block: directed table, random items, predictor check.
`timescale 1ns / 1ps

module tb_gregorian_date_offset;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LATENCY = 9;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               cmd = gdo_pkg::CMD_ADD;
    logic [13:0]        year = 14'd1;
    logic [3:0]         month = 4'd1;
    logic [4:0]         day = 5'd1;
    logic signed [20:0] offset_days = '0;
    logic [13:0]        other_year = 14'd1;
    logic [3:0]         other_month = 4'd1;
    logic [4:0]         other_day = 5'd1;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [13:0]        out_year;
    logic [3:0]         out_month;
    logic [4:0]         out_day;
    logic signed [22:0] diff_days;
    logic [1:0]         status;

    // One request item as the sender drives it.
    typedef struct {
        logic               c;
        logic [13:0]        y1;
        logic [3:0]         m1;
        logic [4:0]         d1;
        logic signed [20:0] off;
        logic [13:0]        y2;
        logic [3:0]         m2;
        logic [4:0]         d2;
    } date_req_t;

    // One result item.
    typedef struct {
        logic [13:0]        y;
        logic [3:0]         m;
        logic [4:0]         d;
        logic signed [22:0] diff;
        logic [1:0]         st;
    } date_res_t;

    date_res_t pending_results[$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    bit        quiet_out = 1'b0;
    bit        hold_out = 1'b0;

    gregorian_date_offset dut (.*);

    always #4 clk = ~clk;

    // Calendar helpers, written in integer terms and independent of the block's package.
    function automatic bit is_leap(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_days(int y, int m);
        int lens[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m == 2 && is_leap(y))
            return 29;
        return lens[m];
    endfunction

    function automatic bit valid_date(int y, int m, int d);
        if (y < 1 || y > 9999 || m < 1 || m > 12)
            return 1'b0;
        return d >= 1 && d <= month_days(y, m);
    endfunction

    function automatic int day_number(int y, int m, int d);
        int p;
        int n;
        p = y - 1;
        n = p * 365 + p / 4 - p / 100 + p / 400;
        for (int k = 1; k < m; k++)
            n += month_days(y, k);
        return n + d;
    endfunction

    function automatic bit same_res(date_res_t a, date_res_t b);
        return a.y == b.y && a.m == b.m && a.d == b.d && a.diff == b.diff && a.st == b.st;
    endfunction

    // Predicts the result of one item; the year is found from an estimate and walked forward.
    function automatic date_res_t predict_date(date_req_t r);
        date_res_t e;
        int n;
        int yy;
        int mm;
        e = '{default: '0};
        if (r.c == gdo_pkg::CMD_ADD)
        begin
            if (!valid_date(r.y1, r.m1, r.d1))
                e.st = gdo_pkg::ST_BAD_DATE;
            else
            begin
                n = day_number(r.y1, r.m1, r.d1) + int'(r.off);
                if (n < 1 || n > 3652059)
                    e.st = gdo_pkg::ST_RANGE;
                else
                begin
                    yy = (n - 1) / 366 + 1;
                    while (day_number(yy + 1, 1, 1) <= n)
                        yy++;
                    n = n - day_number(yy, 1, 1);
                    mm = 1;
                    while (n >= month_days(yy, mm))
                    begin
                        n -= month_days(yy, mm);
                        mm++;
                    end
                    e.y = 14'(yy);
                    e.m = 4'(mm);
                    e.d = 5'(n + 1);
                end
            end
        end
        else
        begin
            if (!valid_date(r.y1, r.m1, r.d1) || !valid_date(r.y2, r.m2, r.d2))
                e.st = gdo_pkg::ST_BAD_DATE;
            else
                e.diff = 23'(day_number(r.y1, r.m1, r.d1) - day_number(r.y2, r.m2, r.d2));
        end
        return e;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    // Offers one item at the falling edge and holds it until the block takes it.
    // Valid stays high afterwards unless the sender idles or the caller drops it.
    task automatic send_date(date_req_t r, bit idle);
        while (idle && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        cmd         <= r.c;
        year        <= r.y1;
        month       <= r.m1;
        day         <= r.d1;
        offset_days <= r.off;
        other_year  <= r.y2;
        other_month <= r.m2;
        other_day   <= r.d2;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random date, mostly valid, with a share of broken fields so every bit toggles.
    task automatic random_date(output logic [13:0] y, output logic [3:0] m,
                               output logic [4:0] d);
        int pick;
        pick = $urandom_range(99);
        if (pick < 80)
        begin
            if (pick < 10)
                y = $urandom_range(1) ? 14'd1 : 14'd9999;
            else
                y = 14'($urandom_range(9999, 1));
            m = 4'($urandom_range(12, 1));
            d = 5'($urandom_range(month_days(y, m), 1));
        end
        else
        begin
            y = 14'($urandom);
            m = 4'($urandom);
            d = 5'($urandom);
        end
    endtask

    // Receiver: random idling, a quiet stretch, and a long hold-off counted by the main sequence.
    always @(negedge clk)
    begin
        if (hold_out)
            out_ready <= 1'b0;
        else if (quiet_out)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 18);
    end

    // Results are checked at the rising edge against the oldest prediction.
    always @(posedge clk)
    begin
        date_res_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result item", 1, 0);
            else
            begin
                e = pending_results.pop_front();
                if (out_year !== e.y)     report_mismatch("out_year", out_year, e.y);
                if (out_month !== e.m)    report_mismatch("out_month", out_month, e.m);
                if (out_day !== e.d)      report_mismatch("out_day", out_day, e.d);
                if (diff_days !== e.diff) report_mismatch("diff_days", diff_days, e.diff);
                if (status !== e.st)      report_mismatch("status", status, e.st);
            end
        end
    end

    // Predictions are queued when the block accepts an item.
    always @(posedge clk)
    begin
        date_req_t r;
        if (rst_n && in_valid && in_ready)
        begin
            r = '{cmd, year, month, day, offset_days, other_year, other_month, other_day};
            pending_results.push_back(predict_date(r));
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        // Directed table: each row is a request and, where known by inspection, its result.
        date_req_t table_req[$];
        date_res_t table_res[$];
        bit        table_has[$];
        date_req_t r;
        date_res_t zero_res;
        int        hold_cycles;

        zero_res = '{default: '0};
        // Extremes of the calendar and the offset.
        table_req.push_back('{gdo_pkg::CMD_ADD, 14'd1, 4'd1, 5'd1, 21'sd0, 14'd1, 4'd1, 5'd1});
        table_res.push_back('{14'd1, 4'd1, 5'd1, 23'sd0, gdo_pkg::ST_OK});
        table_has.push_back(1);
        table_req.push_back('{gdo_pkg::CMD_ADD, 14'd9999, 4'd12, 5'd31, 21'sd0,
                              14'd0, 4'd0, 5'd0});
        table_res.push_back('{14'd9999, 4'd12, 5'd31, 23'sd0, gdo_pkg::ST_OK});
        table_has.push_back(1);
        table_req.push_back('{gdo_pkg::CMD_ADD, 14'd1, 4'd1, 5'd1, -21'sd1, 14'd0, 4'd0, 5'd0});
        table_res.push_back('{14'd0, 4'd0, 5'd0, 23'sd0, gdo_pkg::ST_RANGE});
        table_has.push_back(1);
        table_req.push_back('{gdo_pkg::CMD_ADD, 14'd9999, 4'd12, 5'd31, 21'sd1,
                              14'd0, 4'd0, 5'd0});
        table_res.push_back('{14'd0, 4'd0, 5'd0, 23'sd0, gdo_pkg::ST_RANGE});
        table_has.push_back(1);
        table_req.push_back('{gdo_pkg::CMD_ADD, 14'd5000, 4'd6, 5'd15, 21'sh0FFFFF,
                              14'h3FFF, 4'hF, 5'h1F});
        table_res.push_back(zero_res);
        table_has.push_back(0);
        table_req.push_back('{gdo_pkg::CMD_ADD, 14'd5000, 4'd6, 5'd15, -21'sd1048576,
                              14'd0, 4'd0, 5'd0});
        table_res.push_back(zero_res);
        table_has.push_back(0);
        // Leap rules: a plain leap year, a century, a fourth century.
        table_req.push_back('{gdo_pkg::CMD_ADD, 14'd2024, 4'd2, 5'd28, 21'sd1,
                              14'd0, 4'd0, 5'd0});
        table_res.push_back('{14'd2024, 4'd2, 5'd29, 23'sd0, gdo_pkg::ST_OK});
        table_has.push_back(1);
        table_req.push_back('{gdo_pkg::CMD_ADD, 14'd1900, 4'd2, 5'd28, 21'sd1,
                              14'd0, 4'd0, 5'd0});
        table_res.push_back('{14'd1900, 4'd3, 5'd1, 23'sd0, gdo_pkg::ST_OK});
        table_has.push_back(1);
        table_req.push_back('{gdo_pkg::CMD_ADD, 14'd2000, 4'd2, 5'd29, 21'sd365,
                              14'd0, 4'd0, 5'd0});
        table_res.push_back(zero_res);
        table_has.push_back(0);
        table_req.push_back('{gdo_pkg::CMD_ADD, 14'd1900, 4'd2, 5'd29, 21'sd0,
                              14'd0, 4'd0, 5'd0});
        table_res.push_back('{14'd0, 4'd0, 5'd0, 23'sd0, gdo_pkg::ST_BAD_DATE});
        table_has.push_back(1);
        // Broken first dates: year zero, month zero and thirteen, day zero and too large.
        table_req.push_back('{gdo_pkg::CMD_ADD, 14'd0, 4'd1, 5'd1, 21'sd5, 14'd0, 4'd0, 5'd0});
        table_res.push_back('{14'd0, 4'd0, 5'd0, 23'sd0, gdo_pkg::ST_BAD_DATE});
        table_has.push_back(1);
        table_req.push_back('{gdo_pkg::CMD_ADD, 14'h3FFF, 4'hF, 5'h1F, 21'sd5,
                              14'd0, 4'd0, 5'd0});
        table_res.push_back('{14'd0, 4'd0, 5'd0, 23'sd0, gdo_pkg::ST_BAD_DATE});
        table_has.push_back(1);
        table_req.push_back('{gdo_pkg::CMD_ADD, 14'd2001, 4'd13, 5'd1, 21'sd5,
                              14'd0, 4'd0, 5'd0});
        table_res.push_back('{14'd0, 4'd0, 5'd0, 23'sd0, gdo_pkg::ST_BAD_DATE});
        table_has.push_back(1);
        table_req.push_back('{gdo_pkg::CMD_ADD, 14'd2001, 4'd4, 5'd31, 21'sd5,
                              14'd0, 4'd0, 5'd0});
        table_res.push_back('{14'd0, 4'd0, 5'd0, 23'sd0, gdo_pkg::ST_BAD_DATE});
        table_has.push_back(1);
        table_req.push_back('{gdo_pkg::CMD_ADD, 14'd2001, 4'd0, 5'd0, 21'sd5,
                              14'd0, 4'd0, 5'd0});
        table_res.push_back('{14'd0, 4'd0, 5'd0, 23'sd0, gdo_pkg::ST_BAD_DATE});
        table_has.push_back(1);
        // Differences: equal dates, the full span both ways, a span over a leap day, and broken dates on either side.
        table_req.push_back('{gdo_pkg::CMD_DIFF, 14'd1234, 4'd5, 5'd6, 21'sh0FFFFF,
                              14'd1234, 4'd5, 5'd6});
        table_res.push_back('{14'd0, 4'd0, 5'd0, 23'sd0, gdo_pkg::ST_OK});
        table_has.push_back(1);
        table_req.push_back('{gdo_pkg::CMD_DIFF, 14'd9999, 4'd12, 5'd31, 21'sd0,
                              14'd1, 4'd1, 5'd1});
        table_res.push_back('{14'd0, 4'd0, 5'd0, 23'sd3652058, gdo_pkg::ST_OK});
        table_has.push_back(1);
        table_req.push_back('{gdo_pkg::CMD_DIFF, 14'd1, 4'd1, 5'd1, 21'sd0,
                              14'd9999, 4'd12, 5'd31});
        table_res.push_back('{14'd0, 4'd0, 5'd0, -23'sd3652058, gdo_pkg::ST_OK});
        table_has.push_back(1);
        table_req.push_back('{gdo_pkg::CMD_DIFF, 14'd2000, 4'd3, 5'd1, 21'sd0,
                              14'd2000, 4'd2, 5'd28});
        table_res.push_back('{14'd0, 4'd0, 5'd0, 23'sd2, gdo_pkg::ST_OK});
        table_has.push_back(1);
        table_req.push_back('{gdo_pkg::CMD_DIFF, 14'd2000, 4'd3, 5'd1, 21'sd0,
                              14'd10000, 4'd1, 5'd1});
        table_res.push_back('{14'd0, 4'd0, 5'd0, 23'sd0, gdo_pkg::ST_BAD_DATE});
        table_has.push_back(1);
        table_req.push_back('{gdo_pkg::CMD_DIFF, 14'd2000, 4'd3, 5'd1, 21'sd0,
                              14'd2023, 4'd2, 5'd29});
        table_res.push_back('{14'd0, 4'd0, 5'd0, 23'sd0, gdo_pkg::ST_BAD_DATE});
        table_has.push_back(1);
        table_req.push_back('{gdo_pkg::CMD_DIFF, 14'd0, 4'd0, 5'd0, 21'sd0,
                              14'd1, 4'd1, 5'd1});
        table_res.push_back('{14'd0, 4'd0, 5'd0, 23'sd0, gdo_pkg::ST_BAD_DATE});
        table_has.push_back(1);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Hand-typed rows are checked here against the predictor as well as by the monitor.
        foreach (table_req[i])
        begin
            if (table_has[i] && !same_res(predict_date(table_req[i]), table_res[i]))
                report_mismatch($sformatf("table row %0d prediction", i), 1, 0);
            send_date(table_req[i], 1'b1);
        end
        in_valid <= 1'b0;

        // Sender pauses until every expected result is back.
        while (pending_results.size() != 0)
            @(negedge clk);

        // Long hold-off at the receiver while the sender keeps offering items.
        fork
            begin
                hold_out = 1'b1;
                hold_cycles = 0;
                while (hold_cycles < 60)
                begin
                    @(negedge clk);
                    hold_cycles++;
                end
                hold_out = 1'b0;
            end
        join_none

        for (int n = 0; n < 500; n++)
        begin
            quiet_out = (n >= 200 && n < 280);
            r.c = 1'($urandom_range(1));
            random_date(r.y1, r.m1, r.d1);
            random_date(r.y2, r.m2, r.d2);
            case ($urandom_range(3))
                0:       r.off = 21'($urandom);
                1:       r.off = $signed(21'($urandom_range(800))) - 21'sd400;
                2:       r.off = $urandom_range(1) ? 21'sh0FFFFF : 21'sh100000;
                default: r.off = $signed(21'($urandom_range(80000))) - 21'sd40000;
            endcase
            send_date(r, (n < 200 || n >= 280));
        end
        in_valid <= 1'b0;
        quiet_out = 1'b0;

        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (LATENCY * 4) @(negedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
